// File: design/tts_pkg.sv
// Package for the tick task scheduler table: sizes, codes and the slot entry type.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_OUT   = 8;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_DELETE   = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_DELETED = 3'd2,
        ST_TICK    = 3'd3,
        ST_RUN     = 3'd4,
        ST_IDLE    = 3'd5
    } status_t;

    typedef struct packed {
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
    } slot_entry_t;

    function automatic logic [2:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[2:0];
    endfunction

endpackage

`default_nettype wire

// File: design/tts_mem.sv
// Slot table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tts_mem
    import tts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output slot_entry_t            rd_data,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire slot_entry_t       wr_data
);

    slot_entry_t mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/tts_ctrl.sv
// Scheduler sequencer: slot walk, read-modify-write of the table, used flags and results.
`timescale 1ns / 1ps
`default_nettype none

module tts_ctrl
    import tts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        command,
    input  wire logic [15:0]       first_delay,
    input  wire logic [15:0]       reload_period,
    input  wire logic [2:0]        target_slot,
    output logic                   rd_en,
    output logic [IDX_W-1:0]       rd_addr,
    input  wire slot_entry_t       rd_data,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output slot_entry_t            wr_data,
    output logic                   result_valid,
    output logic [2:0]             slot,
    output logic [2:0]             status,
    output logic                   last
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_FIN   = 5'b01000,
        S_ADD   = 5'b10000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [15:0]          delay_reg, delay_next;
    logic [15:0]          period_reg, period_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 p_valid_reg, p_valid_next;
    logic [IDX_W-1:0]     p_idx_reg, p_idx_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0]     hold_idx_reg, hold_idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 res_valid_reg, res_valid_next;
    logic [2:0]           res_slot_reg, res_slot_next;
    status_t              res_status_reg, res_status_next;
    logic                 res_last_reg, res_last_next;

    logic                 accept;
    logic                 p_used;
    logic [15:0]          delay_dec;
    logic [IDX_W-1:0]     del_idx;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign p_used    = p_valid_reg && used_reg[p_idx_reg];
    assign delay_dec = rd_data.delay - 16'd1;
    assign del_idx   = IDX_W'(target_slot);

    assign rd_en   = (state_reg == S_WALK);
    assign rd_addr = idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        delay_next      = delay_reg;
        period_next     = period_reg;
        idx_next        = idx_reg;
        p_valid_next    = (state_reg == S_WALK);
        p_idx_next      = idx_reg;
        used_next       = used_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        cnt_next        = cnt_reg;
        res_valid_next  = 1'b0;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        wr_en           = 1'b0;
        wr_addr         = p_idx_reg;
        wr_data         = rd_data;

        // stage 2 of the walk: modify and write back
        if (p_used)
        begin
            if (cmd_reg == CMD_TICK)
            begin
                if (rd_data.delay != 16'd0)
                begin
                    wr_en         = 1'b1;
                    wr_data.delay = delay_dec;
                    if (delay_dec == 16'd0)
                    begin
                        wr_data.delay = rd_data.period;
                        if (rd_data.pending != 8'hFF)
                        begin
                            wr_data.pending = rd_data.pending + 8'd1;
                        end
                    end
                end
            end
            else if (rd_data.pending != 8'd0 && cnt_reg < CNT_W'(MAX_OUT))
            begin
                wr_en           = 1'b1;
                wr_data.pending = rd_data.pending - 8'd1;
                cnt_next        = cnt_reg + CNT_W'(1);
                hold_valid_next = 1'b1;
                hold_idx_next   = p_idx_reg;
                if (hold_valid_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_slot_next   = to_slot(hold_idx_reg);
                    res_status_next = ST_RUN;
                    res_last_next   = 1'b0;
                end
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = cmd_t'(command);
                    delay_next      = (first_delay == 16'd0) ? 16'd1 : first_delay;
                    period_next     = reload_period;
                    idx_next        = '0;
                    cnt_next        = '0;
                    hold_valid_next = 1'b0;
                    unique case (cmd_t'(command))
                        CMD_TICK, CMD_DISPATCH:
                        begin
                            state_next = S_WALK;
                        end
                        CMD_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        CMD_DELETE:
                        begin
                            if (32'(target_slot) < NUM_SLOTS)
                            begin
                                used_next[del_idx] = 1'b0;
                            end
                            res_valid_next  = 1'b1;
                            res_slot_next   = target_slot;
                            res_status_next = ST_DELETED;
                            res_last_next   = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next     = S_IDLE;
                res_valid_next = 1'b1;
                res_last_next  = 1'b1;
                if (cmd_reg == CMD_TICK)
                begin
                    res_slot_next   = 3'd0;
                    res_status_next = ST_TICK;
                end
                else if (hold_valid_reg)
                begin
                    res_slot_next   = to_slot(hold_idx_reg);
                    res_status_next = ST_RUN;
                end
                else
                begin
                    res_slot_next   = 3'd0;
                    res_status_next = ST_IDLE;
                end
            end
            S_ADD:
            begin
                if (!used_reg[idx_reg])
                begin
                    wr_en             = 1'b1;
                    wr_addr           = idx_reg;
                    wr_data.delay     = delay_reg;
                    wr_data.period    = period_reg;
                    wr_data.pending   = 8'd0;
                    used_next[idx_reg] = 1'b1;
                    state_next        = S_IDLE;
                    res_valid_next    = 1'b1;
                    res_slot_next     = to_slot(idx_reg);
                    res_status_next   = ST_ADDED;
                    res_last_next     = 1'b1;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next      = S_IDLE;
                    res_valid_next  = 1'b1;
                    res_slot_next   = 3'd0;
                    res_status_next = ST_FULL;
                    res_last_next   = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            p_valid_reg    <= 1'b0;
            used_reg       <= '0;
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            res_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            cmd_reg        <= CMD_TICK;
        end
        else
        begin
            state_reg      <= state_next;
            p_valid_reg    <= p_valid_next;
            used_reg       <= used_next;
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
            res_valid_reg  <= res_valid_next;
            idx_reg        <= idx_next;
            cmd_reg        <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg      <= delay_next;
        period_reg     <= period_next;
        p_idx_reg      <= p_idx_next;
        hold_idx_reg   <= hold_idx_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign slot         = res_slot_reg;
    assign status       = res_status_reg;
    assign last         = res_last_reg;

endmodule

`default_nettype wire

// File: design/tick_task_scheduler_table.sv
// Tick task scheduler table: 8 slots of timed tasks held in a RAM with registered read data.
// Tick and dispatch walk the table one slot per cycle through a read/modify/write pipe:
// busy until the pipe drains, one item at a time; the final result shows as busy drops.
// Dispatch results stream out during the walk, at most one per cycle.
// Add scans used flags one slot per cycle until a free or the last slot; delete never sets busy.
// Reset marks all slots unused at once; results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module tick_task_scheduler_table
    import tts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] first_delay,
    input  wire logic [15:0] reload_period,
    input  wire logic [2:0]  target_slot,
    output logic             result_valid,
    output logic [2:0]       slot,
    output logic [2:0]       status,
    output logic             last
);

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    slot_entry_t      rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_entry_t      wr_data;

    tts_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .first_delay   (first_delay),
        .reload_period (reload_period),
        .target_slot   (target_slot),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .result_valid  (result_valid),
        .slot          (slot),
        .status        (status),
        .last          (last)
    );

    tts_mem u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire
